/* rtl/flipdot_dot_command_sequencer_defines.svh */
// assertion helpers shared by the sequencer rtl
`ifndef FLIPDOT_DOT_COMMAND_SEQUENCER_DEFINES_SVH
`define FLIPDOT_DOT_COMMAND_SEQUENCER_DEFINES_SVH

// same-cycle implication on clk, disabled while arst_n is low
`define FDCS_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication on clk, disabled while arst_n is low
`define FDCS_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/fdcs_pkg.sv */
`timescale 1ns / 1ps
package fdcs_pkg;

	localparam int COLS_PER_MODULE = 28;
	localparam int COLS_PER_DIGIT = 7;
	localparam int ROWS_PER_DRIVER = 14;
	localparam int ROWS_PER_DIGIT = 7;
	localparam int X_MAX = 255;
	localparam int QUOT_MAX = X_MAX / COLS_PER_MODULE;

	localparam logic [6:0] ADDR_MODULE = 7'h40;
	localparam logic [6:0] ADDR_COLUMN = 7'h42;
	localparam logic [6:0] ADDR_ROW = 7'h44;

	localparam logic [7:0] BYTE_ALL_OFF = 8'hFF;
	localparam logic [7:0] BYTE_NONE = 8'h00;
	localparam logic [7:0] COLUMN_MASK = 8'h7E;
	localparam logic [7:0] ROW_ENABLE_MASK = 8'h0F;

	localparam logic REG_MODULE_MAP = 1'b0;
	localparam logic REG_FLIP_TIME = 1'b1;

	localparam logic [23:0] MODULE_MAP_RESET = 24'd16434824;
	localparam logic [15:0] FLIP_TIME_RESET = 16'd500;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_WAIT = 1'b1;

	localparam logic FUNC_DOT = 1'b0;
	localparam logic FUNC_FRAME_END = 1'b1;

	typedef enum logic [2:0] {
		ST_DISABLE,
		ST_COLUMN,
		ST_ROW,
		ST_ENABLE,
		ST_WAIT,
		ST_CLEAR,
		ST_FRAME
	} step_t;

	typedef struct packed {
		logic [7:0] module_byte;
		logic [7:0] column_byte;
		logic [7:0] row_byte;
	} fdcs_bytes_t;

endpackage

/* rtl/flipdot_dot_command_sequencer.sv */
`timescale 1ns / 1ps
`include "flipdot_dot_command_sequencer_defines.svh"
// flip-dot dot command sequencer
// input stream: one command per beat; tuser is func (0 dot, 1 end of frame),
// tdata holds x, y and dot_on. output stream: one bus write or wait per beat,
// tuser is kind (0 write, 1 wait), tlast marks the final beat of a command.
// apb port: register 0 module_map (24 bits), register 1 flip_time_us (16 bits).
// commands wait in the command register; beats leave from the output register.
// throughput: a dot command takes six output beats when the module byte or the
// column bits differ from the remembered ones, else four; end of frame takes
// one. one beat leaves per cycle from the output register unless stalled, and
// the next command is taken as the previous one's final beat enters that register.
// reset clears the remembered bytes (module 0x00, column 0xff), loads the
// register defaults and empties the command and output registers.
// when the receiver stalls, the output beat holds and the command register
// holds its place; input tready drops until the final beat can move on.
module flipdot_dot_command_sequencer #(
	parameter int MAX_MODULES = 8
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // x[7:0], y[12:8], dot_on[13], zero[15:14]
	input  logic        s_tuser,   // func

	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // bus_addr[6:0], data[14:7], wait_us[30:15], zero[31]
	output logic        m_tuser,   // kind
	output logic        m_tlast,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import fdcs_pkg::*;

	logic [23:0] module_map_q;
	logic [15:0] flip_time_q;
	logic [7:0]  last_module_q;
	logic [7:0]  last_column_q;

	logic        cfg_write;
	fdcs_bytes_t dec_bytes;
	logic        accept;
	logic        changed;
	step_t       start_step;

	logic        job_valid_q;
	step_t       step_q;
	step_t       step_next;
	fdcs_bytes_t bytes_q;
	logic        changed_q;

	logic        adv;
	logic        beat_kind;
	logic [6:0]  beat_addr;
	logic [7:0]  beat_data;
	logic [15:0] beat_wait;
	logic        beat_last;

	logic        m_tvalid_q;
	logic        m_kind_q;
	logic [6:0]  m_addr_q;
	logic [7:0]  m_data_q;
	logic [15:0] m_wait_q;
	logic        m_last_q;

	// configuration port
	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			module_map_q <= MODULE_MAP_RESET;
			flip_time_q <= FLIP_TIME_RESET;
		end else if (cfg_write) begin
			case (paddr[2])
				REG_MODULE_MAP: module_map_q <= pwdata[23:0];
				REG_FLIP_TIME:  flip_time_q <= pwdata[15:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MODULE_MAP: prdata = {8'b0, module_map_q};
			REG_FLIP_TIME:  prdata = {16'b0, flip_time_q};
			default:        prdata = '0;
		endcase
	end

	// command decode
	fdcs_decode #(
		.MAX_MODULES(MAX_MODULES)
	) u_decode (
		.x(s_tdata[7:0]),
		.y(s_tdata[12:8]),
		.dot_on(s_tdata[13]),
		.module_map(module_map_q),
		.bytes(dec_bytes)
	);

	assign accept = s_tvalid && s_tready;
	assign changed = (dec_bytes.module_byte != last_module_q)
		|| ((dec_bytes.column_byte & COLUMN_MASK) != last_column_q);

	always_comb begin
		if (s_tuser == FUNC_FRAME_END) begin
			start_step = ST_FRAME;
		end else if (changed) begin
			start_step = ST_DISABLE;
		end else begin
			start_step = ST_COLUMN;
		end
	end

	// remembered bytes follow command order, so they update as a command is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_module_q <= BYTE_NONE;
			last_column_q <= BYTE_ALL_OFF;
		end else if (accept) begin
			if (s_tuser == FUNC_FRAME_END) begin
				last_module_q <= BYTE_NONE;
				last_column_q <= BYTE_ALL_OFF;
			end else if (changed) begin
				last_module_q <= dec_bytes.module_byte;
				last_column_q <= dec_bytes.column_byte & COLUMN_MASK;
			end
		end
	end

	// command register and beat step
	assign adv = job_valid_q && (!m_tvalid_q || m_tready);
	assign s_tready = !job_valid_q || (adv && beat_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			step_q <= ST_FRAME;
		end else if (accept) begin
			job_valid_q <= 1'b1;
			step_q <= start_step;
		end else if (adv && beat_last) begin
			job_valid_q <= 1'b0;
		end else if (adv) begin
			step_q <= step_next;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bytes_q <= dec_bytes;
			changed_q <= changed;
		end
	end

	always_comb begin
		beat_kind = KIND_WRITE;
		beat_addr = '0;
		beat_data = '0;
		beat_wait = '0;
		beat_last = 1'b0;
		step_next = step_q;
		case (step_q)
			ST_DISABLE: begin
				beat_addr = ADDR_MODULE;
				beat_data = BYTE_ALL_OFF;
				step_next = ST_COLUMN;
			end
			ST_COLUMN: begin
				beat_addr = ADDR_COLUMN;
				beat_data = bytes_q.column_byte;
				step_next = ST_ROW;
			end
			ST_ROW: begin
				beat_addr = ADDR_ROW;
				beat_data = bytes_q.row_byte;
				step_next = changed_q ? ST_ENABLE : ST_WAIT;
			end
			ST_ENABLE: begin
				beat_addr = ADDR_MODULE;
				beat_data = bytes_q.module_byte;
				step_next = ST_WAIT;
			end
			ST_WAIT: begin
				beat_kind = KIND_WAIT;
				beat_wait = flip_time_q;
				step_next = ST_CLEAR;
			end
			ST_CLEAR: begin
				beat_addr = ADDR_ROW;
				beat_data = bytes_q.row_byte & ROW_ENABLE_MASK;
				beat_last = 1'b1;
			end
			ST_FRAME: begin
				beat_addr = ADDR_MODULE;
				beat_data = BYTE_ALL_OFF;
				beat_last = 1'b1;
			end
			default: begin
				beat_last = 1'b1;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_kind_q <= beat_kind;
			m_addr_q <= beat_addr;
			m_data_q <= beat_data;
			m_wait_q <= beat_wait;
			m_last_q <= beat_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser = m_kind_q;
	assign m_tlast = m_last_q;
	assign m_tdata = {1'b0, m_wait_q, m_data_q, m_addr_q};

	`FDCS_ASSERT_NOW(a_wait_not_last, m_tvalid && m_tuser == KIND_WAIT, !m_tlast,
		"wait beat marked as final beat")
	`FDCS_ASSERT_NOW(a_wait_clean, m_tvalid && m_tuser == KIND_WAIT,
		m_tdata[14:0] == 15'd0, "wait beat carries bus address or data")
	`FDCS_ASSERT_NOW(a_enable_after_change, job_valid_q && step_q == ST_ENABLE, changed_q,
		"module enable scheduled without a change of remembered bytes")
	`FDCS_ASSERT_NEXT(a_frame_end_clears, accept && s_tuser == FUNC_FRAME_END,
		last_module_q == BYTE_NONE && last_column_q == BYTE_ALL_OFF,
		"frame end did not reset remembered bytes")

endmodule

/* rtl/fdcs_decode.sv */
`timescale 1ns / 1ps
module fdcs_decode #(
	parameter int MAX_MODULES = 8
) (
	input  logic [7:0]               x,
	input  logic [4:0]               y,
	input  logic                     dot_on,
	input  logic [23:0]              module_map,
	output fdcs_pkg::fdcs_bytes_t    bytes
);
	import fdcs_pkg::*;

	logic [3:0] quot;
	logic [2:0] grp_lut [QUOT_MAX + 1];
	logic [2:0] grp;
	logic [4:0] shamt;
	logic [23:0] map_shifted;
	logic [2:0] modnum;
	logic [7:0] x_rem;
	logic [4:0] x_rem5;
	logic [1:0] col_digit;
	logic [2:0] col_seg;
	logic [4:0] col;
	logic [4:0] col_p;
	logic [4:0] y_mod;
	logic row_digit;
	logic [2:0] row_seg;
	logic [4:0] row;
	logic [4:0] row_p;
	logic low;
	logic dot_off;

	// column group modulo the module count, worked out at elaboration
	for (genvar k = 0; k <= QUOT_MAX; k++) begin : g_grp
		assign grp_lut[k] = 3'(k % MAX_MODULES);
	end

	// x / 28 by threshold count
	always_comb begin
		quot = '0;
		for (int k = 1; k <= QUOT_MAX; k++) begin
			if (x >= 8'(COLS_PER_MODULE * k)) begin
				quot = quot + 4'd1;
			end
		end
	end

	always_comb begin
		dot_off = ~dot_on;

		grp = grp_lut[quot];
		shamt = 5'(grp) * 5'd3;
		map_shifted = module_map >> shamt;
		modnum = map_shifted[2:0];

		x_rem = x - 8'(COLS_PER_MODULE) * {4'b0, quot};
		x_rem5 = x_rem[4:0];
		col_digit = 2'({1'b0, x_rem5 >= 5'(COLS_PER_DIGIT)})
			+ 2'({1'b0, x_rem5 >= 5'(2 * COLS_PER_DIGIT)})
			+ 2'({1'b0, x_rem5 >= 5'(3 * COLS_PER_DIGIT)});
		col_seg = 3'(x_rem5 - 5'(COLS_PER_DIGIT) * {3'b0, col_digit}) + 3'd1;
		col = {col_digit, col_seg};

		if (y >= 5'(2 * ROWS_PER_DRIVER)) begin
			y_mod = y - 5'(2 * ROWS_PER_DRIVER);
		end else if (y >= 5'(ROWS_PER_DRIVER)) begin
			y_mod = y - 5'(ROWS_PER_DRIVER);
		end else begin
			y_mod = y;
		end
		row_digit = (y_mod >= 5'(ROWS_PER_DIGIT));
		row_seg = 3'(y_mod - (row_digit ? 5'(ROWS_PER_DIGIT) : 5'd0)) + 3'd1;
		row = {row_digit, dot_off, row_seg};
		low = (y < 5'(ROWS_PER_DRIVER));

		// column address goes out mirrored
		col_p = {col[0], col[1], col[2], col[3], col[4]};
		// row address: segment bits mirrored, digit bit and dot_off bit swapped
		row_p = {row[3], row[4], row[0], row[1], row[2]};

		bytes.module_byte = ~(8'h80 >> modnum);
		bytes.column_byte = {row_p[0], dot_off, col_p, 1'b0};
		bytes.row_byte = {~low, dot_on, low, dot_on, row_p[4:1]};
	end

endmodule
